### sv/digital_net_point_generator_assert.svh
// Assertion macros used by the point generator top level.
`ifndef DIGITAL_NET_POINT_GENERATOR_ASSERT_SVH
`define DIGITAL_NET_POINT_GENERATOR_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define DNPG_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dnpg check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define DNPG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dnpg check failed");

`endif

### sv/dnpg_pkg.sv
// Shared types and constants of the digital net point generator.
package dnpg_pkg;

	localparam int WORD_W       = 32;
	localparam int DIM_W        = 4;
	localparam int MAX_DIMS_DEF = 16;
	localparam int DIGITS_DEF   = 32;
	localparam int OUT_LIMIT    = 16;

	localparam logic [5:0] NUM_BITS_RST = 6'd32;
	localparam logic [4:0] NUM_DIMS_RST = 5'd16;

	localparam logic REG_NUM_BITS = 1'b0;
	localparam logic REG_NUM_DIMS = 1'b1;

	typedef enum logic [1:0] {
		MODE_LOAD    = 2'd0,
		MODE_CLASSIC = 2'd1,
		MODE_GRAY    = 2'd2,
		MODE_NEXT    = 2'd3
	} mode_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_RUN  = 1'b1
	} feed_state_t;

	typedef struct packed {
		mode_t       mode;
		logic [3:0]  load_dim;
		logic [4:0]  load_bit;
		logic [31:0] direction_value;
		logic [31:0] position;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  out_dim;
		logic [31:0] coordinate;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic              valid;
		logic [DIM_W-1:0]  dim;
		logic              last;
		logic [WORD_W-1:0] bits;
		logic [WORD_W-1:0] acc;
	} lane_t;

endpackage

### sv/digital_net_point_generator.sv
// Top level of the base-2 digital net point generator: registers, cell chain and result port.
// A generate transaction passes the feed and the digit cell chain before its first coordinate appears,
// then gives one coordinate per cycle; busy stays high while the feed runs or any cell holds a
// valid lane, so the digit cell chain must drain before the next transaction is accepted.
// A load transaction writes one direction word at its accepting edge and leaves busy low.
// Reset sets num_bits 32, num_dims 16 and a zero current point; the table is undefined.
module digital_net_point_generator import dnpg_pkg::*; #(
	parameter int MAX_DIMS = MAX_DIMS_DEF,
	parameter int DIGITS   = DIGITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  in_item_t    item,
	output logic        strobe,
	output out_item_t   result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

`include "digital_net_point_generator_assert.svh"

	localparam int NCELL = (DIGITS < WORD_W) ? DIGITS : WORD_W;
	localparam int DLIM  = (MAX_DIMS < OUT_LIMIT) ? MAX_DIMS : OUT_LIMIT;

	logic [5:0]       num_bits_q;
	logic [4:0]       num_dims_q;
	logic [5:0]       nd;
	logic [4:0]       nm;
	logic             accept, gen_go, load_go;
	lane_t            chain [NCELL+1];
	logic [DIM_W-1:0] feed_la;
	logic             feed_active;
	logic [NCELL-1:0] cell_vld;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_bits_q <= NUM_BITS_RST;
			num_dims_q <= NUM_DIMS_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_NUM_BITS: num_bits_q <= pwdata[5:0];
				REG_NUM_DIMS: num_dims_q <= pwdata[4:0];
				default:      num_bits_q <= num_bits_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_NUM_BITS: prdata = {26'd0, num_bits_q};
			REG_NUM_DIMS: prdata = {27'd0, num_dims_q};
			default:      prdata = '0;
		endcase
	end

	assign nd = (num_bits_q > 6'(NCELL)) ? 6'(NCELL) : num_bits_q;
	assign nm = (num_dims_q > 5'(DLIM)) ? 5'(DLIM) : num_dims_q;

	assign accept  = start && !busy;
	assign gen_go  = accept && (item.mode != MODE_LOAD);
	assign load_go = accept && (item.mode == MODE_LOAD) && (32'(item.load_dim) < MAX_DIMS);

	dnpg_feed #(
		.MAX_DIMS(MAX_DIMS)
	) u_feed (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (gen_go),
		.mode    (item.mode),
		.position(item.position),
		.nd      (nd),
		.nm      (nm),
		.wb      (chain[NCELL]),
		.lane    (chain[0]),
		.la_dim  (feed_la),
		.active  (feed_active)
	);

	for (genvar k = 0; k < NCELL; k++) begin : g_cell
		logic             cell_we;
		logic [DIM_W-1:0] cell_la;

		assign cell_we = load_go && (item.load_bit == 5'(k));
		assign cell_la = (k == 0) ? feed_la : chain[(k == 0) ? 0 : k - 1].dim;

		dnpg_cell #(
			.K       (k),
			.MAX_DIMS(MAX_DIMS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.lane_in (chain[k]),
			.la_dim  (cell_la),
			.we      (cell_we),
			.wdim    (item.load_dim),
			.wdata   (item.direction_value),
			.lane_out(chain[k+1])
		);

		assign cell_vld[k] = chain[k+1].valid;
	end

	assign busy = feed_active || (|cell_vld);

	assign strobe            = chain[NCELL].valid;
	assign result.out_dim    = chain[NCELL].dim;
	assign result.coordinate = chain[NCELL].acc;
	assign result.last       = chain[NCELL].last;

	`DNPG_ASSERT_NOW(a_strobe_busy, strobe, busy)
	`DNPG_ASSERT_NEXT(a_gen_busy, gen_go && (nm != 5'd0), busy)
	`DNPG_ASSERT_NEXT(a_last_gap, strobe && result.last, !strobe)
	`DNPG_ASSERT_NEXT(a_contig, strobe && !result.last, strobe)

endmodule

### sv/dnpg_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module dnpg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### sv/dnpg_cell.sv
// One digit cell: holds the direction words of its digit and folds them into the passing lane.
module dnpg_cell import dnpg_pkg::*; #(
	parameter int K        = 0,
	parameter int MAX_DIMS = MAX_DIMS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lane_t             lane_in,
	input  logic [DIM_W-1:0]  la_dim,
	input  logic              we,
	input  logic [DIM_W-1:0]  wdim,
	input  logic [WORD_W-1:0] wdata,
	output lane_t             lane_out
);

	localparam int AW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

	logic [WORD_W-1:0] word;
	logic              valid_q;
	lane_t             lane_d;
	lane_t             lane_q;

	dnpg_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MAX_DIMS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(AW'(wdim)),
		.wdata(wdata),
		.raddr(AW'(la_dim)),
		.rdata(word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= lane_in.valid;
		end
	end

	always_comb begin
		lane_d     = lane_in;
		lane_d.acc = lane_in.bits[K] ? (lane_in.acc ^ word) : lane_in.acc;
	end

	always_ff @(posedge clk) begin
		lane_q <= lane_d;
	end

	always_comb begin
		lane_out       = lane_q;
		lane_out.valid = valid_q;
	end

endmodule

### sv/dnpg_feed.sv
// Dimension sequencer and current-point store that launches coordinates into the cell chain.
module dnpg_feed import dnpg_pkg::*; #(
	parameter int MAX_DIMS = MAX_DIMS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  mode_t             mode,
	input  logic [31:0]       position,
	input  logic [5:0]        nd,
	input  logic [4:0]        nm,
	input  lane_t             wb,
	output lane_t             lane,
	output logic [DIM_W-1:0]  la_dim,
	output logic              active
);

	localparam int AW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

	feed_state_t       state_q, state_d;
	logic [DIM_W-1:0]  cnt_q, cnt_d;
	logic [4:0]        nm_q;
	logic [WORD_W-1:0] bits_q, sel, mask;
	logic              next_q;
	logic              issue;
	logic              vld_s1;
	logic [DIM_W-1:0]  dim_s1;
	logic              last_s1;
	logic              cur_ok_s1;
	logic [MAX_DIMS-1:0] cur_vld_q;
	logic [WORD_W-1:0] cur_word;

	always_comb begin
		for (int k = 0; k < WORD_W; k++) begin
			mask[k] = (6'(k) < nd);
		end
		case (mode)
			MODE_CLASSIC: sel = position;
			MODE_GRAY:    sel = position ^ (position >> 1);
			MODE_NEXT:    sel = position & (~position + 32'd1);
			default:      sel = '0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		issue   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (go && (nm != 5'd0)) begin
					state_d = ST_RUN;
					cnt_d   = '0;
				end
			end
			ST_RUN: begin
				issue = 1'b1;
				cnt_d = cnt_q + 1'b1;
				if ({1'b0, cnt_q} == (nm_q - 5'd1)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			vld_s1    <= 1'b0;
			cur_vld_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			vld_s1  <= issue;
			if (wb.valid) begin
				cur_vld_q[AW'(wb.dim)] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && (state_q == ST_IDLE)) begin
			nm_q   <= nm;
			bits_q <= sel & mask;
			next_q <= (mode == MODE_NEXT);
		end
		dim_s1    <= cnt_q;
		last_s1   <= ({1'b0, cnt_q} == (nm_q - 5'd1));
		cur_ok_s1 <= cur_vld_q[AW'(cnt_q)];
	end

	dnpg_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MAX_DIMS)
	) u_cur (
		.clk  (clk),
		.we   (wb.valid),
		.waddr(AW'(wb.dim)),
		.wdata(wb.acc),
		.raddr(AW'(cnt_q)),
		.rdata(cur_word)
	);

	always_comb begin
		lane.valid = vld_s1;
		lane.dim   = dim_s1;
		lane.last  = last_s1;
		lane.bits  = bits_q;
		lane.acc   = (next_q && cur_ok_s1) ? cur_word : '0;
	end

	assign la_dim = cnt_q;
	assign active = (state_q == ST_RUN) || vld_s1;

endmodule

### verif/tb.sv
// Self-checking testbench for the digital net point generator: loads, point modes and settings.
module tb;
	import dnpg_pkg::*;

	class point_tracker;
		logic [31:0] dir_words [MAX_DIMS_DEF*DIGITS_DEF];
		logic [31:0] point [MAX_DIMS_DEF];
		int          num_bits;
		int          num_dims;
		out_item_t   expected_coords [$];
		int          errors;

		function new();
			num_bits = NUM_BITS_RST;
			num_dims = NUM_DIMS_RST;
			errors   = 0;
			foreach (point[d]) point[d] = '0;
			foreach (dir_words[i]) dir_words[i] = '0;
		endfunction

		function void set_register(logic idx, logic [31:0] value);
			if (idx == REG_NUM_BITS) begin
				num_bits = value[5:0];
			end else begin
				num_dims = value[4:0];
			end
		endfunction

		function int pending();
			return expected_coords.size();
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			$display("mismatch in %s: got %h, expected %h", what, got, want);
			errors++;
		endtask

		// Works out every coordinate that one accepted transaction gives.
		function void note_item(in_item_t it);
			int          digits;
			int          dims;
			int          tz;
			logic [31:0] sel;
			logic [31:0] coord;
			out_item_t   coord_item;
			if (it.mode == MODE_LOAD) begin
				if (it.load_dim < MAX_DIMS_DEF && it.load_bit < DIGITS_DEF)
					dir_words[int'(it.load_dim) * DIGITS_DEF + int'(it.load_bit)] =
						it.direction_value;
				return;
			end
			digits = num_bits;
			if (digits > DIGITS_DEF) digits = DIGITS_DEF;
			if (digits > 32) digits = 32;
			dims = num_dims;
			if (dims > MAX_DIMS_DEF) dims = MAX_DIMS_DEF;
			if (dims > OUT_LIMIT) dims = OUT_LIMIT;
			sel = (it.mode == MODE_GRAY) ? (it.position ^ (it.position >> 1)) : it.position;
			tz = 32;
			for (int k = 31; k >= 0; k--) begin
				if (it.position[k]) tz = k;
			end
			for (int d = 0; d < dims; d++) begin
				if (it.mode == MODE_NEXT) begin
					coord = point[d];
					if (tz < digits) coord ^= dir_words[d * DIGITS_DEF + tz];
				end else begin
					coord = '0;
					for (int k = 0; k < digits; k++) begin
						if (sel[k]) coord ^= dir_words[d * DIGITS_DEF + k];
					end
				end
				point[d]              = coord;
				coord_item.out_dim    = 4'(d);
				coord_item.coordinate = coord;
				coord_item.last       = (d == dims - 1);
				expected_coords.push_back(coord_item);
			end
		endfunction

		task check_coord(out_item_t got);
			out_item_t want;
			if (expected_coords.size() == 0) begin
				report("unexpected coordinate", got.coordinate, '0);
				return;
			end
			want = expected_coords.pop_front();
			if (got.out_dim !== want.out_dim)
				report("out_dim", 32'(got.out_dim), 32'(want.out_dim));
			if (got.coordinate !== want.coordinate)
				report("coordinate", got.coordinate, want.coordinate);
			if (got.last !== want.last) report("last", 32'(got.last), 32'(want.last));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	in_item_t    item;
	logic        strobe;
	out_item_t   result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	point_tracker sb;
	int           sender_idle;

	digital_net_point_generator i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.item    (item),
		.strobe  (strobe),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && strobe === 1'b1) sb.check_coord(result);
	end

	function automatic logic [31:0] pick_word();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_position();
		case ($urandom_range(5))
			0: return $urandom_range(63);
			1: return 32'd1 << $urandom_range(31);
			2: return ~(32'd1 << $urandom_range(31));
			3: return '0;
			default: return $urandom;
		endcase
	endfunction

	function automatic in_item_t random_fields();
		in_item_t it;
		it.mode            = mode_t'($urandom_range(3));
		it.load_dim        = 4'($urandom_range(15));
		it.load_bit        = 5'($urandom_range(31));
		it.direction_value = pick_word();
		it.position        = pick_position();
		return it;
	endfunction

	task automatic send_item(in_item_t it);
		while ($urandom_range(99) < sender_idle) begin
			@(negedge clk);
			start = 1'b0;
		end
		@(negedge clk);
		start = 1'b1;
		item  = it;
		do @(posedge clk); while (busy !== 1'b0);
		sb.note_item(it);
	endtask

	task automatic send_op(mode_t m, logic [31:0] pos);
		in_item_t it;
		it          = random_fields();
		it.mode     = m;
		it.position = pos;
		send_item(it);
	endtask

	task automatic send_load(int d, int k, logic [31:0] value);
		in_item_t it;
		it                 = random_fields();
		it.mode            = MODE_LOAD;
		it.load_dim        = 4'(d);
		it.load_bit        = 5'(k);
		it.direction_value = value;
		send_item(it);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_register(logic idx, logic [31:0] value);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		sb.set_register(idx, value);
	endtask

	task automatic apply_setting(int bits, int dims);
		wait_drained();
		write_register(REG_NUM_BITS, bits);
		write_register(REG_NUM_DIMS, dims);
	endtask

	// Gray-code points followed by runs of next points, mixed with single random transactions.
	task automatic run_random(int count);
		in_item_t    it;
		int          done;
		logic [31:0] pos;
		done = 0;
		while (done < count) begin
			if ($urandom_range(99) < 40) begin
				pos = pick_position();
				send_op(MODE_GRAY, pos);
				done++;
				repeat ($urandom_range(8, 2)) begin
					pos = pos + 1;
					send_op(MODE_NEXT, pos);
					done++;
				end
			end else begin
				it = random_fields();
				send_item(it);
				done++;
			end
		end
	endtask

	initial begin
		int bits;
		int dims;
		sb          = new();
		arst_n      = 1'b0;
		start       = 1'b0;
		item        = '0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		sender_idle = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Dimensions 0 to 3 get every digit and the others digits 0 to 7, so more than
		// eight digits in use always goes with at most four dimensions.
		for (int d = 0; d < MAX_DIMS_DEF; d++) begin
			for (int k = 0; k < DIGITS_DEF; k++) begin
				if (k < 8 || d < 4) send_load(d, k, pick_word());
			end
		end

		// Reset settings, with positions that reach only the low eight digits.
		send_op(MODE_CLASSIC, 32'h0000_0000);
		send_op(MODE_CLASSIC, 32'h0000_00FF);
		send_op(MODE_CLASSIC, 32'h0000_0080);
		send_op(MODE_GRAY, 32'h0000_00FF);
		send_op(MODE_GRAY, 32'h0000_0055);
		send_op(MODE_NEXT, 32'h0000_0000);
		send_op(MODE_NEXT, 32'h0000_0001);
		send_op(MODE_NEXT, 32'h0000_0080);
		send_op(MODE_NEXT, 32'h0000_0002);

		apply_setting(32, 4);
		send_op(MODE_CLASSIC, 32'hFFFF_FFFF);
		send_op(MODE_CLASSIC, 32'h8000_0000);
		send_op(MODE_GRAY, 32'hFFFF_FFFF);
		send_op(MODE_GRAY, 32'h8000_0000);
		send_op(MODE_GRAY, 32'h5555_5555);
		send_op(MODE_NEXT, 32'h8000_0000);
		send_load(3, 31, 32'hFFFF_FFFF);
		send_load(0, 0, 32'h0000_0000);
		send_op(MODE_CLASSIC, 32'hFFFF_FFFF);
		send_op(MODE_NEXT, 32'h8000_0000);

		// A digit count above the chain length is clamped.
		apply_setting(63, 2);
		send_op(MODE_CLASSIC, 32'hFFFF_FFFF);

		// No digits in use gives zero coordinates; no dimensions gives no coordinates.
		apply_setting(0, 3);
		send_op(MODE_CLASSIC, 32'hFFFF_FFFF);
		send_op(MODE_NEXT, 32'h0000_0001);
		apply_setting(8, 0);
		send_op(MODE_CLASSIC, 32'h0000_00FF);

		// With one digit the trailing-zero index of an even position runs past the digits.
		apply_setting(1, 1);
		send_op(MODE_NEXT, 32'h0000_0002);
		send_op(MODE_CLASSIC, 32'hFFFF_FFFF);
		send_op(MODE_GRAY, 32'hFFFF_FFFF);
		send_op(MODE_NEXT, 32'h0000_0001);
		send_op(MODE_NEXT, 32'h0000_0000);

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: apply_setting(32, 4);
				1: apply_setting(1, 1);
				2: apply_setting(32, 1);
				3: apply_setting(8, 16);
				default: begin
					bits = $urandom_range(32, 0);
					dims = (bits > 8) ? $urandom_range(4, 0) : $urandom_range(16, 0);
					apply_setting(bits, dims);
				end
			endcase
			case (ph % 3)
				0: sender_idle = 0;
				1: sender_idle = 75;
				default: sender_idle = 16;
			endcase
			run_random(26);
		end

		wait_drained();
		if (sb.errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#1000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
